// ----- hdl/ba256_pkg.sv -----
// ============================================================================
// ba256_pkg
// Shared widths, item types and the CORDIC step-angle table for the bearing
// block.
// ============================================================================
`default_nettype none

package ba256_pkg;

    // Coordinate and angle widths.
    localparam int COORD_WIDTH = 16;
    localparam int ANGLE_BITS  = 8;

    // Internal CORDIC word: two's complement values and a Q64 turn angle.
    localparam int WORD_W       = 64;
    localparam int CORDIC_STEPS = 62;

    // The larger magnitude is normalized so that its top bit sits here.
    localparam int NORM_BIT      = 60;
    localparam int SHIFT_STAGES  = $clog2(NORM_BIT + 1);

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // 1/(2*pi) in Q66.
    localparam logic [WORD_W-1:0] INV_2PI_Q66 = 64'hA2F9836E4E441529;

    // Octant folding and quadrant flags carried along with an item.
    typedef struct packed {
        logic swap;
        logic dx_neg;
        logic dn_neg;
    } ba256_class_t;

    // One classified item: smaller and larger magnitude plus its flags.
    typedef struct packed {
        logic [COORD_WIDTH-1:0] s;
        logic [COORD_WIDTH-1:0] l;
        ba256_class_t           cls;
    } ba256_item_t;

    typedef logic [CORDIC_STEPS-1:0][WORD_W-1:0] angle_table_t;

    // High half of a 64 by 64 product, used at elaboration only.
    function automatic logic [WORD_W-1:0] mul_high(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [2*WORD_W-1:0] p;
        p = {{WORD_W{1'b0}}, a} * {{WORD_W{1'b0}}, b};
        return p[2*WORD_W-1:WORD_W];
    endfunction

    // Restoring shift-subtract division, used at elaboration only.
    function automatic logic [WORD_W-1:0] udiv(input logic [WORD_W-1:0] num,
                                               input logic [WORD_W-1:0] den);
        logic [WORD_W:0]   rem;
        logic [WORD_W-1:0] quo;
        int                n;
        rem = '0;
        quo = '0;
        for (n = WORD_W - 1; n >= 0; n--) begin
            rem = {rem[WORD_W-1:0], num[n]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[n] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) as a Q64 fraction of a turn, from the truncated arctangent
    // series in Q62 radians.
    function automatic angle_table_t step_angles();
        angle_table_t      t;
        logic [WORD_W-1:0] rad;
        logic [WORD_W-1:0] term;
        int                i;
        int                k;
        int                sh;
        for (i = 0; i < CORDIC_STEPS; i++) begin
            if (i == 0) begin
                t[i] = WORD_W'(1) << 61;
            end else begin
                rad = '0;
                for (k = 0; k < 32; k++) begin
                    sh = i * (2 * k + 1);
                    if (sh <= 62) begin
                        term = udiv(WORD_W'(1) << (62 - sh), WORD_W'(2 * k + 1));
                        if ((k % 2) == 1) begin
                            rad = rad - term;
                        end else begin
                            rad = rad + term;
                        end
                    end
                end
                t[i] = mul_high(rad, INV_2PI_Q66);
            end
        end
        return t;
    endfunction

    localparam angle_table_t STEP_ANGLE = step_angles();

endpackage

`default_nettype wire

// ----- hdl/bearing_angle_256.sv -----
// ============================================================================
// bearing_angle_256
// Bearing from an observer to a target as an 8-bit binary angle.
// ============================================================================
// The block takes one pair of positions per cycle and returns one heading
// per pair, 0 at north, 64 east, 128 south and 192 west, growing clockwise.
// Every stage of the datapath is one register deep, so a new pair can be
// taken in every cycle for as long as results are taken. A pair passes
// through the four-entry queue, six shifter stages that normalize the
// larger magnitude, 62 CORDIC stages, and the output register. When the
// output is stalled the queue takes up to four more pairs before the input
// stops accepting.
`default_nettype none

module bearing_angle_256 (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [ba256_pkg::COORD_WIDTH-1:0]   s_own_x,
    input  wire logic [ba256_pkg::COORD_WIDTH-1:0]   s_own_y,
    input  wire logic [ba256_pkg::COORD_WIDTH-1:0]   s_target_x,
    input  wire logic [ba256_pkg::COORD_WIDTH-1:0]   s_target_y,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [ba256_pkg::ANGLE_BITS-1:0]         m_heading
);

    logic                   push;
    logic                   push_ready;
    ba256_pkg::ba256_item_t push_item;
    logic                   pop_valid;
    logic                   pop;
    ba256_pkg::ba256_item_t pop_item;

    // Classify each transfer and fold it into the first octant.
    ba256_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_own_x    (s_own_x),
        .s_own_y    (s_own_y),
        .s_target_x (s_target_x),
        .s_target_y (s_target_y),
        .push       (push),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // Queue between the front and the CORDIC pipeline.
    ba256_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_item   (pop_item)
    );

    // Angle computation and result register.
    ba256_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop       (pop),
        .pop_item  (pop_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_heading (m_heading)
    );

endmodule

`default_nettype wire

// ----- hdl/ba256_front.sv -----
// ============================================================================
// ba256_front
// Accepts position pairs, forms the exact differences and folds them into
// the first octant.
// ============================================================================
`default_nettype none

module ba256_front (
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [ba256_pkg::COORD_WIDTH-1:0]   s_own_x,
    input  wire logic [ba256_pkg::COORD_WIDTH-1:0]   s_own_y,
    input  wire logic [ba256_pkg::COORD_WIDTH-1:0]   s_target_x,
    input  wire logic [ba256_pkg::COORD_WIDTH-1:0]   s_target_y,
    output logic                                     push,
    input  wire logic                                push_ready,
    output ba256_pkg::ba256_item_t                   push_item
);

    localparam int W = ba256_pkg::COORD_WIDTH;

    logic [W:0]   dx;
    logic [W:0]   dn;
    logic [W:0]   dx_abs;
    logic [W:0]   dn_abs;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic         swap;

    // A transfer goes straight into the queue when it has room.
    assign s_ready = push_ready;
    assign push    = s_valid && push_ready;

    // Differences with north positive, then magnitudes.
    always_comb begin
        dx     = {1'b0, s_target_x} - {1'b0, s_own_x};
        dn     = {1'b0, s_own_y} - {1'b0, s_target_y};
        dx_abs = dx[W] ? ((W+1)'(0) - dx) : dx;
        dn_abs = dn[W] ? ((W+1)'(0) - dn) : dn;
        a      = dx_abs[W-1:0];
        b      = dn_abs[W-1:0];
        swap   = (a > b);
    end

    // Fold into the first octant: the smaller magnitude is the CORDIC y.
    always_comb begin
        push_item.s          = swap ? b : a;
        push_item.l          = swap ? a : b;
        push_item.cls.swap   = swap;
        push_item.cls.dx_neg = dx[W];
        push_item.cls.dn_neg = dn[W];
    end

endmodule

`default_nettype wire

// ----- hdl/ba256_queue.sv -----
// ============================================================================
// ba256_queue
// Short FIFO that decouples the classifying front from the CORDIC back.
// ============================================================================
`default_nettype none

module ba256_queue (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    output logic                        push_ready,
    input  wire ba256_pkg::ba256_item_t push_item,
    output logic                        pop_valid,
    input  wire logic                   pop,
    output ba256_pkg::ba256_item_t      pop_item
);

    localparam int DEPTH = ba256_pkg::QUEUE_DEPTH;
    localparam int PW    = ba256_pkg::QPTR_W;
    localparam int CW    = ba256_pkg::QCNT_W;

    ba256_pkg::ba256_item_t mem_reg [DEPTH];
    logic [PW-1:0]          wr_ptr_reg;
    logic [PW-1:0]          wr_ptr_next;
    logic [PW-1:0]          rd_ptr_reg;
    logic [PW-1:0]          rd_ptr_next;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != CW'(0));
    assign pop_item   = mem_reg[rd_ptr_reg];

    // Pointer and fill count updates, wrapping at the depth.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? PW'(0) : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? PW'(0) : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ba256_back.sv -----
// ============================================================================
// ba256_back
// Normalizing shifter, pipelined vectoring CORDIC, quadrant unfolding and
// rounding to a binary angle.
// ============================================================================
`default_nettype none

module ba256_back (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                pop_valid,
    output logic                                     pop,
    input  wire ba256_pkg::ba256_item_t              pop_item,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [ba256_pkg::ANGLE_BITS-1:0]         m_heading
);

    localparam int WW    = ba256_pkg::WORD_W;
    localparam int NS    = ba256_pkg::SHIFT_STAGES;
    localparam int NC    = ba256_pkg::CORDIC_STEPS;
    localparam int AB    = ba256_pkg::ANGLE_BITS;
    localparam int NB    = ba256_pkg::NORM_BIT;

    localparam logic [WW-1:0] QUARTER = WW'(1) << (WW - 2);
    localparam logic [WW-1:0] HALF    = WW'(1) << (WW - 1);
    localparam logic [WW-1:0] ROUND   = WW'(1) << (WW - 1 - AB);

    // The whole pipeline moves when the output register can take a result.
    logic advance;

    logic [NS-1:0]           nrm_vld_reg;
    logic [WW-1:0]           nrm_s_reg   [NS];
    logic [WW-1:0]           nrm_l_reg   [NS];
    ba256_pkg::ba256_class_t nrm_cls_reg [NS];

    logic [NC-1:0]           cdc_vld_reg;
    logic [WW-1:0]           cdc_x_reg   [NC];
    logic [WW-1:0]           cdc_y_reg   [NC];
    logic [WW-1:0]           cdc_z_reg   [NC];
    ba256_pkg::ba256_class_t cdc_cls_reg [NC];

    logic                    m_valid_reg;
    logic [AB-1:0]           heading_reg;
    logic [AB-1:0]           heading_next;

    assign advance   = !m_valid_reg || m_ready;
    assign pop       = pop_valid && advance;
    assign m_valid   = m_valid_reg;
    assign m_heading = heading_reg;

    // Normalizing shifter: binary search of the shift, one amount per stage.
    for (genvar k = 0; k < NS; k++) begin : g_nrm
        localparam int AMT = 1 << (NS - 1 - k);

        logic                    vld_in;
        logic [WW-1:0]           s_in;
        logic [WW-1:0]           l_in;
        ba256_pkg::ba256_class_t cls_in;
        logic                    do_shift;

        if (k == 0) begin : g_first
            assign vld_in = pop_valid;
            assign s_in   = WW'(pop_item.s);
            assign l_in   = WW'(pop_item.l);
            assign cls_in = pop_item.cls;
        end else begin : g_next
            assign vld_in = nrm_vld_reg[k-1];
            assign s_in   = nrm_s_reg[k-1];
            assign l_in   = nrm_l_reg[k-1];
            assign cls_in = nrm_cls_reg[k-1];
        end

        // Shift when the top bit is still below the target by at least AMT.
        assign do_shift = ((l_in >> (NB + 1 - AMT)) == WW'(0));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                nrm_vld_reg[k] <= 1'b0;
            end else if (advance) begin
                nrm_vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                nrm_s_reg[k]   <= do_shift ? (s_in << AMT) : s_in;
                nrm_l_reg[k]   <= do_shift ? (l_in << AMT) : l_in;
                nrm_cls_reg[k] <= cls_in;
            end
        end
    end

    // Vectoring CORDIC, one micro-rotation per stage. A stage whose y is
    // already zero passes its values through unchanged.
    for (genvar i = 0; i < NC; i++) begin : g_cdc
        logic                    vld_in;
        logic [WW-1:0]           x_in;
        logic [WW-1:0]           y_in;
        logic [WW-1:0]           z_in;
        ba256_pkg::ba256_class_t cls_in;
        logic [WW-1:0]           xs;
        logic [WW-1:0]           ys;
        logic [WW-1:0]           x_out;
        logic [WW-1:0]           y_out;
        logic [WW-1:0]           z_out;

        if (i == 0) begin : g_first
            assign vld_in = nrm_vld_reg[NS-1];
            assign x_in   = nrm_l_reg[NS-1];
            assign y_in   = nrm_s_reg[NS-1];
            assign z_in   = '0;
            assign cls_in = nrm_cls_reg[NS-1];
        end else begin : g_next
            assign vld_in = cdc_vld_reg[i-1];
            assign x_in   = cdc_x_reg[i-1];
            assign y_in   = cdc_y_reg[i-1];
            assign z_in   = cdc_z_reg[i-1];
            assign cls_in = cdc_cls_reg[i-1];
        end

        always_comb begin
            xs = x_in >> i;
            ys = WW'($signed(y_in) >>> i);
            if (y_in == WW'(0)) begin
                x_out = x_in;
                y_out = y_in;
                z_out = z_in;
            end else if (y_in[WW-1]) begin
                x_out = x_in - ys;
                y_out = y_in + xs;
                z_out = z_in - ba256_pkg::STEP_ANGLE[i];
            end else begin
                x_out = x_in + ys;
                y_out = y_in - xs;
                z_out = z_in + ba256_pkg::STEP_ANGLE[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cdc_vld_reg[i] <= 1'b0;
            end else if (advance) begin
                cdc_vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                cdc_x_reg[i]   <= x_out;
                cdc_y_reg[i]   <= y_out;
                cdc_z_reg[i]   <= z_out;
                cdc_cls_reg[i] <= cls_in;
            end
        end
    end

    // Unfold the octant angle by quadrant and round to the nearest unit.
    always_comb begin
        logic [WW-1:0]           phi;
        logic [WW-1:0]           theta;
        logic [WW-1:0]           rounded;
        ba256_pkg::ba256_class_t cls;
        cls = cdc_cls_reg[NC-1];
        phi = cls.swap ? (QUARTER - cdc_z_reg[NC-1]) : cdc_z_reg[NC-1];
        if (!cls.dx_neg) begin
            theta = cls.dn_neg ? (HALF - phi) : phi;
        end else begin
            theta = cls.dn_neg ? (HALF + phi) : (WW'(0) - phi);
        end
        rounded      = theta + ROUND;
        heading_next = rounded[WW-1 -: AB];
    end

    // Output register; it holds while the result waits for a transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= cdc_vld_reg[NC-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            heading_reg <= heading_next;
        end
    end

endmodule

`default_nettype wire
